// ===== hw/rtl/sog_pkg.sv =====
`timescale 1ns / 1ps
package sog_pkg;

    localparam int FREQ_W = 32;
    localparam int VOL_W  = 16;
    localparam int BLEN_W = 13;
    localparam int RATE_W = 18;
    localparam int OUT_W  = 16;

    // status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

// ===== hw/rtl/sog_in_if.sv =====
`timescale 1ns / 1ps
interface sog_in_if;
    import sog_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     command;
    logic [FREQ_W-1:0]        frequency;
    logic signed [VOL_W-1:0]  volume;
    logic [BLEN_W-1:0]        block_length;
    logic                     first_of_block;

    modport source (
        output valid, command, frequency, volume, block_length, first_of_block,
        input  ready
    );
    modport sink (
        input  valid, command, frequency, volume, block_length, first_of_block,
        output ready
    );
endinterface

// ===== hw/rtl/sog_out_if.sv =====
`timescale 1ns / 1ps
interface sog_out_if;
    import sog_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [OUT_W-1:0]  sample_out;
    logic                     last_of_block;

    modport source (
        output valid, sample_out, last_of_block,
        input  ready
    );
    modport sink (
        input  valid, sample_out, last_of_block,
        output ready
    );
endinterface

// ===== hw/rtl/sawtooth_oscillator_glide.sv =====
`timescale 1ns / 1ps
// sawtooth oscillator with linear frequency glide
//
// i_in carries one sample tick per request: command, frequency, volume,
// block_length, first_of_block. o_out carries one sample per tick:
// sample_out and last_of_block. i_cfg_we/i_cfg_wdata write the sample rate
// in Hz; while it is zero, ticks are taken and dropped without a sample.
// write the rate only while the block is idle.
//
// one tick at a time: ready is high only between ticks. a direct-mode or
// gliding tick runs the shared restoring divider once for the phase step;
// a first glide tick whose target differs runs it twice (glide step, then
// phase step), and a tick with no recompute skips it. the next tick can be
// taken in the cycle after the sample is registered.
// the result sits in an output register; if the receiver stalls, the next
// tick is still taken and waits at its end until the register frees up.
// reset clears phase, frequencies, glide state and the sample rate, and
// holds ready low.
module sawtooth_oscillator_glide #(
    parameter int MAX_BLOCK  = 4096,
    parameter int PHASE_BITS = 32
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [sog_pkg::RATE_W-1:0]   i_cfg_wdata,
    sog_in_if.sink                       i_in,
    sog_out_if.source                    o_out
);
    import sog_pkg::*;

    localparam int DVD_W = PHASE_BITS + 16;
    localparam int QUO_W = (PHASE_BITS > FREQ_W) ? PHASE_BITS : FREQ_W;
    localparam logic [BLEN_W-1:0] BLK_CAP =
        BLEN_W'((MAX_BLOCK > 8191) ? 8191 : MAX_BLOCK);

    typedef enum logic [2:0] {
        S_IDLE,
        S_GDIV,
        S_FREQ,
        S_SDIV,
        S_OUT
    } t_state;

    t_state                   r_state;
    logic [RATE_W-1:0]        r_rate;
    logic                     r_cmd;
    logic [FREQ_W-1:0]        r_freq;
    logic signed [VOL_W-1:0]  r_vol;

    // oscillator state
    logic [PHASE_BITS-1:0]    r_phase;
    logic [PHASE_BITS-1:0]    r_step;
    logic [FREQ_W-1:0]        r_cur;
    logic [FREQ_W-1:0]        r_target;
    logic                     r_gsign;
    logic [FREQ_W-1:0]        r_gmag;
    logic                     r_gliding;
    logic [BLEN_W-1:0]        r_index;
    logic [BLEN_W-1:0]        r_size;

    // divider request
    logic                     r_div_start;
    logic [DVD_W-1:0]         r_div_dvd;
    logic [RATE_W-1:0]        r_div_dsr;
    logic [QUO_W-1:0]         div_quo;
    t_div_stat                div_stat;

    // output register
    logic                     r_out_valid;
    logic signed [OUT_W-1:0]  r_sample;
    logic                     r_last;

    logic                     in_acc;
    logic [BLEN_W-1:0]        blen_c;
    logic signed [FREQ_W:0]   diff;
    logic [FREQ_W-1:0]        diff_mag;
    logic [FREQ_W:0]          glide_sum;
    logic [FREQ_W-1:0]        glide_next;
    logic [BLEN_W:0]          index_inc;
    logic signed [OUT_W-1:0]  shape_sample;

    // no request is taken while reset is held
    assign i_in.ready = i_rst_n && (r_state == S_IDLE);
    assign in_acc     = i_in.valid && i_in.ready;

    always_comb begin
        // block length clamp: zero counts as one, cap at the block bound
        if (i_in.block_length == '0) begin
            blen_c = BLEN_W'(1);
        end else if (i_in.block_length > BLK_CAP) begin
            blen_c = BLK_CAP;
        end else begin
            blen_c = i_in.block_length;
        end
        diff     = $signed({1'b0, i_in.frequency}) - $signed({1'b0, r_cur});
        diff_mag = diff[FREQ_W] ? FREQ_W'(-diff) : diff[FREQ_W-1:0];

        // one glide increment, clamped to the frequency range
        if (r_gsign) begin
            glide_sum  = {1'b0, r_cur} - {1'b0, r_gmag};
            glide_next = glide_sum[FREQ_W] ? '0 : glide_sum[FREQ_W-1:0];
        end else begin
            glide_sum  = {1'b0, r_cur} + {1'b0, r_gmag};
            glide_next = glide_sum[FREQ_W] ? '1 : glide_sum[FREQ_W-1:0];
        end
        index_inc = {1'b0, r_index} + (BLEN_W+1)'(1);
    end

    sog_div #(
        .DVD_W (DVD_W),
        .QUO_W (QUO_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (r_div_dvd),
        .i_divisor  (r_div_dsr),
        .o_quotient (div_quo),
        .o_stat     (div_stat)
    );

    sog_shape u_shape (
        .i_phase_top (r_phase[PHASE_BITS-1 -: 16]),
        .i_volume    (r_vol),
        .o_sample    (shape_sample)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rate      <= '0;
            r_cmd       <= 1'b0;
            r_freq      <= '0;
            r_vol       <= '0;
            r_phase     <= '0;
            r_step      <= '0;
            r_cur       <= '0;
            r_target    <= '0;
            r_gsign     <= 1'b0;
            r_gmag      <= '0;
            r_gliding   <= 1'b0;
            r_index     <= '0;
            r_size      <= BLEN_W'(1);
            r_div_start <= 1'b0;
            r_div_dvd   <= '0;
            r_div_dsr   <= '0;
            r_out_valid <= 1'b0;
            r_sample    <= '0;
            r_last      <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            if (i_cfg_we) begin
                r_rate <= i_cfg_wdata;
            end
            if (o_out.valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    // a tick with no sample rate is swallowed
                    if (in_acc && (r_rate != '0)) begin
                        r_cmd   <= i_in.command;
                        r_freq  <= i_in.frequency;
                        r_vol   <= i_in.volume;
                        r_state <= S_FREQ;
                        if (i_in.first_of_block) begin
                            r_size    <= blen_c;
                            r_index   <= '0;
                            r_gliding <= 1'b0;
                            if (!i_in.command) begin
                                r_target <= i_in.frequency;
                                if (i_in.frequency != r_cur) begin
                                    // glide step = |target - current| / block size
                                    r_gsign     <= diff[FREQ_W];
                                    r_gliding   <= 1'b1;
                                    r_div_dvd   <= DVD_W'(diff_mag);
                                    r_div_dsr   <= RATE_W'(blen_c);
                                    r_div_start <= 1'b1;
                                    r_state     <= S_GDIV;
                                end
                            end
                        end
                    end
                end
                S_GDIV: begin
                    if (div_stat.done) begin
                        r_gmag  <= div_quo[FREQ_W-1:0];
                        r_state <= S_FREQ;
                    end
                end
                S_FREQ: begin
                    // phase step = frequency * 2^(PHASE_BITS-16) / sample rate
                    r_div_dsr <= r_rate;
                    if (r_cmd) begin
                        r_gliding   <= 1'b0;
                        r_cur       <= r_freq;
                        r_div_dvd   <= DVD_W'(r_freq) << (PHASE_BITS - 16);
                        r_div_start <= 1'b1;
                        r_state     <= S_SDIV;
                    end else if (r_gliding) begin
                        // last tick of the block lands on the target exactly
                        if (index_inc >= {1'b0, r_size}) begin
                            r_cur     <= r_target;
                            r_div_dvd <= DVD_W'(r_target) << (PHASE_BITS - 16);
                        end else begin
                            r_cur     <= glide_next;
                            r_div_dvd <= DVD_W'(glide_next) << (PHASE_BITS - 16);
                        end
                        r_div_start <= 1'b1;
                        r_state     <= S_SDIV;
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_SDIV: begin
                    if (div_stat.done) begin
                        r_step  <= div_quo[PHASE_BITS-1:0];
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // hold here while the previous sample is still waiting
                    if (!r_out_valid || o_out.ready) begin
                        r_out_valid <= 1'b1;
                        r_sample    <= shape_sample;
                        r_phase     <= r_phase + r_step;
                        if (index_inc >= {1'b0, r_size}) begin
                            r_last  <= 1'b1;
                            r_index <= '0;
                            if (r_gliding) begin
                                r_cur     <= r_target;
                                r_gliding <= 1'b0;
                            end
                        end else begin
                            r_last  <= 1'b0;
                            r_index <= index_inc[BLEN_W-1:0];
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.sample_out    = r_sample;
    assign o_out.last_of_block = r_last;
endmodule

// ===== hw/rtl/sog_div.sv =====
`timescale 1ns / 1ps
module sog_div #(
    parameter int DVD_W = 48,
    parameter int QUO_W = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DVD_W-1:0]              i_dividend,
    input  logic [sog_pkg::RATE_W-1:0]    i_divisor,
    output logic [QUO_W-1:0]              o_quotient,
    output sog_pkg::t_div_stat            o_stat
);
    import sog_pkg::*;

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [RATE_W-1:0] r_rem;
    logic [RATE_W-1:0] r_dsr;
    logic [DVD_W-1:0]  r_dvd;
    logic [QUO_W-1:0]  r_quo;
    logic [CNT_W-1:0]  r_cnt;
    logic              r_busy;
    logic              r_done;

    logic [RATE_W:0]   rem_sh;
    logic              ge;
    logic [RATE_W:0]   rem_sub;

    // one restoring step per cycle, msb first
    always_comb begin
        rem_sh  = {r_rem, r_dvd[DVD_W-1]};
        ge      = rem_sh >= {1'b0, r_dsr};
        rem_sub = rem_sh - {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem  <= '0;
            r_dsr  <= '0;
            r_dvd  <= '0;
            r_quo  <= '0;
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= '0;
                r_dsr  <= i_divisor;
                r_dvd  <= i_dividend;
                r_quo  <= '0;
                r_cnt  <= CNT_W'(DVD_W);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= ge ? rem_sub[RATE_W-1:0] : rem_sh[RATE_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], ge};
                r_dvd <= r_dvd << 1;
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

// ===== hw/rtl/sog_shape.sv =====
`timescale 1ns / 1ps
module sog_shape (
    input  logic [15:0]                        i_phase_top,
    input  logic signed [sog_pkg::VOL_W-1:0]   i_volume,
    output logic signed [sog_pkg::OUT_W-1:0]   o_sample
);
    import sog_pkg::*;

    logic signed [17:0] d;
    logic signed [33:0] prod;
    logic signed [17:0] r;

    // d = 2q - 65536, product floored by 2^16, then saturated
    always_comb begin
        d    = $signed({1'b0, i_phase_top, 1'b0}) - 18'sd65536;
        prod = 34'(i_volume) * 34'(d);
        r    = prod[33:16];
        if (r > 18'sd32767) begin
            o_sample = 16'sh7fff;
        end else if (r < -18'sd32768) begin
            o_sample = -16'sh8000;
        end else begin
            o_sample = r[OUT_W-1:0];
        end
    end
endmodule
